@@ rtl/rsrg_pkg.sv @@
// ----------------------------------------------------------------------------
// rsrg_pkg
// Shared types and constants for the replacement-selection run generator.
// ----------------------------------------------------------------------------
package rsrg_pkg;

  localparam int CAPACITY_DEF = 32;
  localparam int KEY_W        = 16;
  localparam int PAYLOAD_W    = 32;

  localparam logic CMD_PUSH  = 1'b0;
  localparam logic CMD_FLUSH = 1'b1;

  typedef struct packed {
    logic                 command;
    logic [KEY_W-1:0]     record_key;
    logic [PAYLOAD_W-1:0] record_payload;
  } in_item_t;

  typedef struct packed {
    logic [KEY_W-1:0]     out_key;
    logic [PAYLOAD_W-1:0] out_payload;
    logic                 run_start;
    logic                 last;
  } out_item_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic capture;    // latch input transaction
    logic scan_start; // clear scan minimum, start at slot 0
    logic scan_step;  // examine one slot
    logic fill;       // write new record at fill_count
    logic thaw;       // clear all frozen flags if all valid are frozen
    logic replace;    // emit minimum and write new record in its slot
    logic drain;      // emit minimum and move last entry into its slot
    logic reset_run;  // after flush: clear flags, empty, run pending
  } dp_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic is_flush;
    logic full;
    logic empty;
    logic scan_done;
    logic found;
    logic last_one;
  } dp_sts_t;

endpackage

@@ rtl/rsrg_ram.sv @@
// ----------------------------------------------------------------------------
// rsrg_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module rsrg_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/rsrg_datapath.sv @@
// ----------------------------------------------------------------------------
// rsrg_datapath
// Record store, frozen flags, sequential minimum scan and result register.
// ----------------------------------------------------------------------------
module rsrg_datapath #(
  parameter int CAPACITY = rsrg_pkg::CAPACITY_DEF
) (
  input  logic                rst,
  input  logic                clk,
  input  rsrg_pkg::in_item_t  in_item,
  input  rsrg_pkg::dp_cmd_t   cmd,
  output rsrg_pkg::dp_sts_t   sts,
  output rsrg_pkg::out_item_t result
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  logic                           cmd_flush;
  logic [rsrg_pkg::KEY_W-1:0]     new_key;
  logic [rsrg_pkg::PAYLOAD_W-1:0] new_payload;

  logic [CAPACITY-1:0] frozen;
  logic [CAPACITY-1:0] frozen_drain;
  logic [CW-1:0]       fill_count;
  logic                run_pending;

  logic [CW-1:0]       scan_idx;
  logic                scan_go;
  logic                scan_rd;     // read data for scan_idx-1 valid
  logic [AW-1:0]       rd_slot;
  logic                have_min;
  logic [AW-1:0]       min_slot;
  logic [rsrg_pkg::KEY_W-1:0]     min_key;
  logic [rsrg_pkg::PAYLOAD_W-1:0] min_payload;

  logic                           ram_we;
  logic [AW-1:0]                  ram_waddr;
  logic [rsrg_pkg::KEY_W-1:0]     ram_wkey;
  logic [rsrg_pkg::PAYLOAD_W-1:0] ram_wpay;
  logic [AW-1:0]                  ram_raddr;
  logic [rsrg_pkg::KEY_W-1:0]     rd_key;
  logic [rsrg_pkg::PAYLOAD_W-1:0] rd_pay;

  logic [AW-1:0]    last_slot;
  logic [CAPACITY-1:0] valid_mask;
  logic             all_frozen;
  logic             moving;

  assign last_slot = AW'(fill_count - CW'(1));

  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      valid_mask[i] = (CW'(i) < fill_count);
    end
  end

  assign all_frozen = (fill_count != '0) && ((frozen & valid_mask) == valid_mask);

  // During drain the read port's default address (last_slot) fetches the last entry for the move.
  assign moving = cmd.drain;

  // Step requests past the last valid slot are ignored.
  assign scan_go = cmd.scan_step && (scan_idx != fill_count);

  always_comb begin
    frozen_drain            = frozen;
    frozen_drain[min_slot]  = frozen[last_slot];
    frozen_drain[last_slot] = 1'b0;
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = AW'(fill_count);
    ram_wkey  = new_key;
    ram_wpay  = new_payload;
    if (cmd.fill) begin
      ram_we = 1'b1;
    end else if (cmd.replace) begin
      ram_we    = 1'b1;
      ram_waddr = min_slot;
    end else if (cmd.drain) begin
      ram_we    = (min_slot != last_slot);
      ram_waddr = min_slot;
      ram_wkey  = rd_key;
      ram_wpay  = rd_pay;
    end
  end

  assign ram_raddr = scan_go ? AW'(scan_idx) : last_slot;

  rsrg_ram #(.WIDTH(rsrg_pkg::KEY_W), .DEPTH(CAPACITY)) u_key_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wkey),
    .raddr(ram_raddr),
    .rdata(rd_key)
  );

  rsrg_ram #(.WIDTH(rsrg_pkg::PAYLOAD_W), .DEPTH(CAPACITY)) u_pay_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wpay),
    .raddr(ram_raddr),
    .rdata(rd_pay)
  );

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cmd_flush   <= in_item.command;
      new_key     <= in_item.record_key;
      new_payload <= in_item.record_payload;
    end
  end

  // Scan: one slot read per cycle, compare the registered read data in the cycle after.
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_idx <= '0;
      scan_rd  <= 1'b0;
      have_min <= 1'b0;
    end else if (cmd.scan_start) begin
      scan_idx <= '0;
      scan_rd  <= 1'b0;
      have_min <= 1'b0;
    end else begin
      scan_rd <= scan_go;
      if (scan_go) begin
        scan_idx <= scan_idx + CW'(1);
        rd_slot  <= AW'(scan_idx);
      end
      if (scan_rd && !frozen[rd_slot] &&
          (!have_min || rd_key < min_key)) begin
        have_min    <= 1'b1;
        min_slot    <= rd_slot;
        min_key     <= rd_key;
        min_payload <= rd_pay;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frozen      <= '0;
      fill_count  <= '0;
      run_pending <= 1'b1;
    end else begin
      if (cmd.fill) begin
        frozen[AW'(fill_count)] <= 1'b0;
        fill_count <= fill_count + CW'(1);
      end
      if (cmd.thaw && all_frozen) begin
        frozen      <= '0;
        run_pending <= 1'b1;
      end
      if (cmd.replace) begin
        frozen[min_slot] <= (new_key < min_key);
        run_pending      <= 1'b0;
      end
      if (cmd.drain) begin
        frozen      <= frozen_drain;
        fill_count  <= fill_count - CW'(1);
        run_pending <= 1'b0;
      end
      if (cmd.reset_run) begin
        frozen      <= '0;
        fill_count  <= '0;
        run_pending <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.replace || moving) begin
      result.out_key     <= min_key;
      result.out_payload <= min_payload;
      result.run_start   <= run_pending;
      result.last        <= cmd.drain && (fill_count == CW'(1));
    end
  end

  assign sts.is_flush  = cmd_flush;
  assign sts.full      = (fill_count == CW'(CAPACITY));
  assign sts.empty     = (fill_count == '0);
  assign sts.scan_done = (scan_idx == fill_count) && !scan_rd;
  assign sts.found     = have_min;
  assign sts.last_one  = (fill_count == CW'(1));

  always_ff @(posedge clk) begin
    if (!rst) begin
      assert (fill_count <= CW'(CAPACITY))
        else $error("fill count above capacity");
      assert (!(cmd.replace && cmd.drain))
        else $error("replace and drain together");
    end
  end

  a_fill_not_full: assert property (@(posedge clk) disable iff (rst)
    cmd.fill |-> fill_count < CW'(CAPACITY))
    else $error("fill into full store");
  a_emit_has_min: assert property (@(posedge clk) disable iff (rst)
    (cmd.replace || cmd.drain) |-> have_min)
    else $error("emit without minimum");
  a_drain_shrinks: assert property (@(posedge clk) disable iff (rst)
    cmd.drain |=> fill_count == $past(fill_count) - CW'(1))
    else $error("drain did not shrink store");

endmodule

@@ rtl/rsrg_ctrl.sv @@
// ----------------------------------------------------------------------------
// rsrg_ctrl
// Controller: sequences fill, thaw, scan, replace and drain steps.
// ----------------------------------------------------------------------------
module rsrg_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  rsrg_pkg::dp_sts_t sts,
  output rsrg_pkg::dp_cmd_t cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_DEC   = 3'd1;
  localparam logic [2:0] S_SCAN  = 3'd2;
  localparam logic [2:0] S_EMIT  = 3'd3;
  localparam logic [2:0] S_POST  = 3'd4;
  localparam logic [2:0] S_WAIT  = 3'd5;
  localparam logic [2:0] S_FETCH = 3'd6;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       out_valid_next;
  logic       flushing;
  logic       flushing_next;

  // Drain emits and moves the last entry in the same cycle; move data is read in S_FETCH.
  always_comb begin
    cmd            = '0;
    state_next     = state;
    out_valid_next = out_valid && !out_ready;
    flushing_next  = flushing;
    in_ready       = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = !out_valid;
        if (in_valid && !out_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_DEC;
        end
      end
      S_DEC: begin
        if (sts.is_flush) begin
          if (sts.empty) begin
            state_next = S_IDLE;
          end else begin
            flushing_next  = 1'b1;
            cmd.thaw       = 1'b1;
            cmd.scan_start = 1'b1;
            state_next     = S_SCAN;
          end
        end else if (!sts.full) begin
          cmd.fill   = 1'b1;
          state_next = S_IDLE;
        end else begin
          flushing_next  = 1'b0;
          cmd.thaw       = 1'b1;
          cmd.scan_start = 1'b1;
          state_next     = S_SCAN;
        end
      end
      S_SCAN: begin
        if (sts.scan_done) begin
          state_next = flushing ? S_FETCH : S_EMIT;
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      S_FETCH: begin
        // last-slot read issued by default address; data ready next cycle
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (!out_valid || out_ready) begin
          out_valid_next = sts.found;
          if (!sts.found) begin
            state_next = S_IDLE;
          end else if (flushing) begin
            cmd.drain  = 1'b1;
            state_next = sts.last_one ? S_WAIT : S_POST;
          end else begin
            cmd.replace = 1'b1;
            state_next  = S_POST;
          end
        end
      end
      S_POST: begin
        cmd.thaw       = 1'b1;
        cmd.scan_start = 1'b1;
        state_next     = flushing ? S_SCAN : S_IDLE;
      end
      S_WAIT: begin
        cmd.reset_run = 1'b1;
        flushing_next = 1'b0;
        state_next    = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      flushing  <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
      flushing  <= flushing_next;
    end
  end

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> state == S_IDLE)
    else $error("input taken while busy");
  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    (cmd.replace || cmd.drain) |-> (!out_valid || out_ready))
    else $error("result overwritten");
  a_one_op: assert property (@(posedge clk) disable iff (rst)
    $countones({cmd.fill, cmd.replace, cmd.drain, cmd.reset_run}) <= 1)
    else $error("conflicting commands");

endmodule

@@ rtl/replacement_selection_run_generator_top.sv @@
// ----------------------------------------------------------------------------
// replacement_selection_run_generator_top
// Replacement-selection run generator: sorted runs for an external sort.
// ----------------------------------------------------------------------------
//   channel | handshake            | payload
//   input   | in_valid / in_ready  | in_item  (command, record_key, record_payload)
//   output  | out_valid / out_ready| out_item (out_key, out_payload, run_start, last)
//
// A fill push captures the record and writes it at the fill count. A replacing
// push runs the one-slot-per-cycle minimum scan over the key RAM, then replaces.
// A flush repeats the scan, a last-slot fetch and a draining emission per record.
// Reset (rst, synchronous) empties the store; no clearing pass is needed.
// A stalled output holds the block before its next emission and keeps in_ready low.
// ----------------------------------------------------------------------------
module replacement_selection_run_generator_top #(
  parameter int CAPACITY = rsrg_pkg::CAPACITY_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  rsrg_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_ready,
  output rsrg_pkg::out_item_t out_item
);

  rsrg_pkg::dp_cmd_t cmd;
  rsrg_pkg::dp_sts_t sts;

  rsrg_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  rsrg_datapath #(.CAPACITY(CAPACITY)) u_dp (
    .rst    (rst),
    .clk    (clk),
    .in_item(in_item),
    .cmd    (cmd),
    .sts    (sts),
    .result (out_item)
  );

endmodule
